### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### src/mrm_pkg.sv
// types, constants and helper functions of the response matcher
package mrm_pkg;

    localparam int SLAVE_ENTRIES   = 16;
    localparam int SLOTS_PER_SLAVE = 16;
    localparam int CMD_DEPTH       = SLAVE_ENTRIES * SLOTS_PER_SLAVE;

    localparam int SLAVE_W = (SLAVE_ENTRIES > 1) ? $clog2(SLAVE_ENTRIES) : 1;
    localparam int SLOT_W  = (SLOTS_PER_SLAVE > 1) ? $clog2(SLOTS_PER_SLAVE) : 1;
    localparam int CMD_AW  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int SCAN_W  = ((SLAVE_W > SLOT_W) ? SLAVE_W : SLOT_W) + 1;
    localparam int IDX_W   = SCAN_W - 1;
    localparam int COUNT_W = 5;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;

    typedef enum logic [1:0] {
        OP_SET_SLAVE = 2'd0,
        OP_LOAD_SLOT = 2'd1,
        OP_MARK_LAST = 2'd2,
        OP_MATCH     = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        STAT_OK            = 3'd0,
        STAT_NOT_READ      = 3'd1,
        STAT_BAD_FUNCTION  = 3'd2,
        STAT_INTEGRITY     = 3'd3,
        STAT_UNKNOWN_SLAVE = 3'd4,
        STAT_NO_COMMAND    = 3'd5
    } status_e;

    typedef enum logic [1:0] {
        SRC_OFFERED = 2'd0,
        SRC_LAST    = 2'd1,
        SRC_TABLE   = 2'd2
    } src_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SLAVE_SCAN,
        S_LAST_CMP,
        S_SLOT_SCAN,
        S_DELIVER
    } state_e;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  slave_index;
        logic [3:0]  slot_index;
        logic [7:0]  station_address;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [7:0]  byte_count;
        logic        frame_intact;
        logic        offered_valid;
        logic [7:0]  offered_station;
        logic [7:0]  offered_function;
    } req_t;

    typedef struct packed {
        status_e     status;
        logic [1:0]  read_kind;
        logic [7:0]  station_out;
        logic [15:0] start_out;
        logic [15:0] quantity_out;
        src_e        command_source;
        logic [3:0]  matched_slot;
    } res_t;

    typedef struct packed {
        logic [7:0]  station;
        logic [7:0]  fcode;
        logic [15:0] start;
        logic [15:0] quantity;
    } cmd_t;

    function automatic logic [7:0] expected_count(logic [7:0] fc, logic [15:0] q);
        logic [15:0] qm;
        logic [7:0]  n;
        qm = q - 16'd1;
        n  = 8'd0;
        if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE)
        begin
            n = (q == 16'd0) ? 8'd1 : 8'(qm >> 3) + 8'd1;
        end
        else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT)
        begin
            n = {q[6:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic agrees(logic [7:0] rs, logic [7:0] rf, logic [7:0] rb,
                                    logic [7:0] cs, logic [7:0] cf, logic [15:0] cq);
        return (rs == cs) && (rf == cf) && (rb == expected_count(rf, cq));
    endfunction

    function automatic logic [CMD_AW-1:0] cmd_addr(logic [SLAVE_W-1:0] s,
                                                   logic [SLOT_W-1:0] t);
        return CMD_AW'(CMD_AW'(s) * CMD_AW'(SLOTS_PER_SLAVE) + CMD_AW'(t));
    endfunction

endpackage

### src/mrm_req_if.sv
// request channel of the response matcher
interface mrm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  slave_index;
    logic [3:0]  slot_index;
    logic [7:0]  station_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  byte_count;
    logic        frame_intact;
    logic        offered_valid;
    logic [7:0]  offered_station;
    logic [7:0]  offered_function;

    modport source (
        output valid, operation, slave_index, slot_index, station_address,
               function_code, start_address, quantity, byte_count, frame_intact,
               offered_valid, offered_station, offered_function,
        input  ready
    );

    modport sink (
        input  valid, operation, slave_index, slot_index, station_address,
               function_code, start_address, quantity, byte_count, frame_intact,
               offered_valid, offered_station, offered_function,
        output ready
    );
endinterface

### src/mrm_rsp_if.sv
// result channel of the response matcher
interface mrm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  read_kind;
    logic [7:0]  station_out;
    logic [15:0] start_out;
    logic [15:0] quantity_out;
    logic [1:0]  command_source;
    logic [3:0]  matched_slot;

    modport source (
        output valid, status, read_kind, station_out, start_out, quantity_out,
               command_source, matched_slot,
        input  ready
    );

    modport sink (
        input  valid, status, read_kind, station_out, start_out, quantity_out,
               command_source, matched_slot,
        output ready
    );
endinterface

### src/modbus_response_matcher_top.sv
// top level of the modbus rtu response matcher
//
// requests arrive on req (valid/ready); a request is taken when both are high.
// operation 0 sets a slave station, 1 loads a command slot, 2 sets or clears
// the last-sent mark, 3 matches a response header. every request gives one
// result on rsp (valid/ready), held in an output register until taken.
// the user must write slave_count through cfg_we/cfg_wdata while the block
// is idle; the block itself does not enforce this. one request is worked on
// at a time. operations 0 to 2, and a match that is rejected or hits the
// offered command, go from the exec state straight to the deliver state;
// otherwise the slave table is read one entry a cycle from its ram, the
// last-sent command is compared if the slave has a mark, and if that fails
// the command slots of the slave are read one a cycle from the command ram.
// the next request is taken once the result has moved to the output register,
// so a stalled receiver stops the input once one more result waits behind it.
// reset clears the slot-loaded and last-sent marks and slave_count; station
// and command entries are undefined until written, and no clearing pass runs.
module modbus_response_matcher_top (
    input  logic         clk,
    input  logic         rst_n,
    mrm_req_if.sink      req,
    mrm_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata
);
    import mrm_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [SCAN_W-1:0]  slave_limit;
    req_t               in_req;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    res_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               st_we;
    logic [SLAVE_W-1:0] st_waddr;
    logic [7:0]         st_wdata;
    logic               st_re;
    logic [SLAVE_W-1:0] st_raddr;
    logic [7:0]         st_rdata;
    logic               cmd_we;
    logic [CMD_AW-1:0]  cmd_waddr;
    cmd_t               cmd_wdata;
    logic               cmd_re;
    logic [CMD_AW-1:0]  cmd_raddr;
    cmd_t               cmd_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // saturate at the table size
    assign slave_limit = (int'(count_reg) > SLAVE_ENTRIES) ? SCAN_W'(SLAVE_ENTRIES)
                                                           : SCAN_W'(count_reg);

    assign in_req = '{operation:        req.operation,
                      slave_index:      req.slave_index,
                      slot_index:       req.slot_index,
                      station_address:  req.station_address,
                      function_code:    req.function_code,
                      start_address:    req.start_address,
                      quantity:         req.quantity,
                      byte_count:       req.byte_count,
                      frame_intact:     req.frame_intact,
                      offered_valid:    req.offered_valid,
                      offered_station:  req.offered_station,
                      offered_function: req.offered_function};

    mrm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_req      (in_req),
        .slave_limit (slave_limit),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata),
        .st_re       (st_re),
        .st_raddr    (st_raddr),
        .st_rdata    (st_rdata),
        .cmd_we      (cmd_we),
        .cmd_waddr   (cmd_waddr),
        .cmd_wdata   (cmd_wdata),
        .cmd_re      (cmd_re),
        .cmd_raddr   (cmd_raddr),
        .cmd_rdata   (cmd_rdata)
    );

    mrm_ram #(
        .WIDTH (8),
        .DEPTH (SLAVE_ENTRIES)
    ) u_station_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mrm_ram #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_command_ram (
        .clk   (clk),
        .we    (cmd_we),
        .waddr (cmd_waddr),
        .wdata (cmd_wdata),
        .re    (cmd_re),
        .raddr (cmd_raddr),
        .rdata (cmd_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.read_kind      = out_reg.read_kind;
    assign rsp.station_out    = out_reg.station_out;
    assign rsp.start_out      = out_reg.start_out;
    assign rsp.quantity_out   = out_reg.quantity_out;
    assign rsp.command_source = out_reg.command_source;
    assign rsp.matched_slot   = out_reg.matched_slot;

endmodule

### src/mrm_ram.sv
// generic simple dual-port ram with registered read data
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mrm_seq.sv
// sequencer: executes one request, walks the slave and command tables
module mrm_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mrm_pkg::req_t               in_req,
    input  logic [mrm_pkg::SCAN_W-1:0]  slave_limit,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mrm_pkg::res_t               res,
    output logic                        st_we,
    output logic [mrm_pkg::SLAVE_W-1:0] st_waddr,
    output logic [7:0]                  st_wdata,
    output logic                        st_re,
    output logic [mrm_pkg::SLAVE_W-1:0] st_raddr,
    input  logic [7:0]                  st_rdata,
    output logic                        cmd_we,
    output logic [mrm_pkg::CMD_AW-1:0]  cmd_waddr,
    output mrm_pkg::cmd_t               cmd_wdata,
    output logic                        cmd_re,
    output logic [mrm_pkg::CMD_AW-1:0]  cmd_raddr,
    input  mrm_pkg::cmd_t               cmd_rdata
);
    import mrm_pkg::*;

    state_e              state_reg, state_next;
    req_t                req_reg, req_next;
    res_t                res_reg, res_next;
    logic [SCAN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [SLAVE_W-1:0]  slave_idx_reg, slave_idx_next;
    logic [CMD_DEPTH-1:0] loaded_reg, loaded_next;
    logic [SLAVE_ENTRIES-1:0] marked_reg, marked_next;
    logic [SLOT_W-1:0]   last_slot_reg [SLAVE_ENTRIES];
    logic [SLOT_W-1:0]   last_slot_next [SLAVE_ENTRIES];

    op_e                 op;
    logic                idx_ok;
    logic                slave_ok;
    logic                not_read;
    logic                bad_fc;
    logic                broken;
    logic                offered_hit;
    logic                cmd_agree;
    logic [SLAVE_W-1:0]  found_idx;
    logic [SLOT_W-1:0]   scan_slot;
    logic [SLOT_W-1:0]   found_last;
    logic                slave_more;
    logic                slave_hit;
    logic                slot_more;
    logic                slot_hit;
    res_t                res_accept;

    assign op          = op_e'(req_reg.operation);
    assign slave_ok    = int'(req_reg.slave_index) < SLAVE_ENTRIES;
    assign idx_ok      = slave_ok && (int'(req_reg.slot_index) < SLOTS_PER_SLAVE);
    assign not_read    = req_reg.function_code > FC_READ_INPUT;
    assign bad_fc      = req_reg.function_code == 8'd0;
    assign broken      = !req_reg.frame_intact;
    assign offered_hit = req_reg.offered_valid
                      && agrees(req_reg.station_address, req_reg.function_code,
                                req_reg.byte_count, req_reg.offered_station,
                                req_reg.offered_function, req_reg.quantity);
    assign cmd_agree   = agrees(req_reg.station_address, req_reg.function_code,
                                req_reg.byte_count, cmd_rdata.station,
                                cmd_rdata.fcode, cmd_rdata.quantity);

    assign found_idx   = cmp_idx_reg[SLAVE_W-1:0];
    assign scan_slot   = cmp_idx_reg[SLOT_W-1:0];
    assign found_last  = last_slot_reg[found_idx];
    assign slave_more  = rd_idx_reg < slave_limit;
    assign slave_hit   = pend_reg && (st_rdata == req_reg.station_address);
    assign slot_more   = rd_idx_reg < SCAN_W'(SLOTS_PER_SLAVE);
    assign slot_hit    = pend_reg && loaded_reg[cmd_addr(slave_idx_reg, scan_slot)]
                      && cmd_agree;

    // common part of an accepted match
    always_comb
    begin
        res_accept              = '0;
        res_accept.status       = STAT_OK;
        res_accept.read_kind    = 2'(req_reg.function_code - 8'd1);
        res_accept.station_out  = req_reg.station_address;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op != OP_MATCH || not_read || bad_fc || broken || offered_hit)
                begin
                    state_next = S_DELIVER;
                end
                else
                begin
                    state_next = S_SLAVE_SCAN;
                end
            end
            S_SLAVE_SCAN:
            begin
                if (slave_hit)
                begin
                    state_next = marked_reg[found_idx] ? S_LAST_CMP : S_SLOT_SCAN;
                end
                else if (!slave_more)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_LAST_CMP:
            begin
                state_next = cmd_agree ? S_DELIVER : S_SLOT_SCAN;
            end
            S_SLOT_SCAN:
            begin
                if (slot_hit || !slot_more)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = state_reg == S_IDLE;
        res_valid      = state_reg == S_DELIVER;
        res            = res_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        slave_idx_next = slave_idx_reg;
        loaded_next    = loaded_reg;
        marked_next    = marked_reg;
        last_slot_next = last_slot_reg;
        st_we          = 1'b0;
        st_waddr       = SLAVE_W'(req_reg.slave_index);
        st_wdata       = req_reg.station_address;
        st_re          = 1'b0;
        st_raddr       = rd_idx_reg[SLAVE_W-1:0];
        cmd_we         = 1'b0;
        cmd_waddr      = cmd_addr(SLAVE_W'(req_reg.slave_index), SLOT_W'(req_reg.slot_index));
        cmd_wdata      = '{station:  req_reg.station_address,
                           fcode:    req_reg.function_code,
                           start:    req_reg.start_address,
                           quantity: req_reg.quantity};
        cmd_re         = 1'b0;
        cmd_raddr      = cmd_addr(slave_idx_reg, rd_idx_reg[SLOT_W-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_req;
                end
            end
            S_EXEC:
            begin
                res_next        = '0;
                res_next.status = STAT_OK;
                rd_idx_next     = '0;
                unique case (op)
                    OP_SET_SLAVE:
                    begin
                        st_we = slave_ok;
                    end
                    OP_LOAD_SLOT:
                    begin
                        if (idx_ok)
                        begin
                            cmd_we                 = 1'b1;
                            loaded_next[cmd_waddr] = 1'b1;
                        end
                    end
                    OP_MARK_LAST:
                    begin
                        if (idx_ok)
                        begin
                            marked_next[SLAVE_W'(req_reg.slave_index)] = req_reg.offered_valid;
                            if (req_reg.offered_valid)
                            begin
                                last_slot_next[SLAVE_W'(req_reg.slave_index)] =
                                    SLOT_W'(req_reg.slot_index);
                            end
                        end
                    end
                    OP_MATCH:
                    begin
                        priority if (not_read)
                        begin
                            res_next.status = STAT_NOT_READ;
                        end
                        else if (bad_fc)
                        begin
                            res_next.status = STAT_BAD_FUNCTION;
                        end
                        else if (broken)
                        begin
                            res_next.status = STAT_INTEGRITY;
                        end
                        else if (offered_hit)
                        begin
                            res_next                = res_accept;
                            res_next.command_source = SRC_OFFERED;
                            res_next.start_out      = req_reg.start_address;
                            res_next.quantity_out   = req_reg.quantity;
                        end
                    end
                    default:
                    begin
                        res_next.status = STAT_OK;
                    end
                endcase
            end
            S_SLAVE_SCAN:
            begin
                if (slave_hit)
                begin
                    slave_idx_next = found_idx;
                    rd_idx_next    = '0;
                    cmd_re         = marked_reg[found_idx];
                    cmd_raddr      = cmd_addr(found_idx, found_last);
                end
                else if (slave_more)
                begin
                    st_re        = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + SCAN_W'(1);
                end
                else
                begin
                    res_next.status = STAT_UNKNOWN_SLAVE;
                end
            end
            S_LAST_CMP:
            begin
                if (cmd_agree)
                begin
                    res_next                = res_accept;
                    res_next.command_source = SRC_LAST;
                    res_next.matched_slot   = 4'(last_slot_reg[slave_idx_reg]);
                    res_next.start_out      = cmd_rdata.start;
                    res_next.quantity_out   = cmd_rdata.quantity;
                end
                rd_idx_next = '0;
            end
            S_SLOT_SCAN:
            begin
                if (slot_hit)
                begin
                    res_next                = res_accept;
                    res_next.command_source = SRC_TABLE;
                    res_next.matched_slot   = 4'(scan_slot);
                    res_next.start_out      = cmd_rdata.start;
                    res_next.quantity_out   = cmd_rdata.quantity;
                end
                else if (slot_more)
                begin
                    cmd_re       = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + SCAN_W'(1);
                end
                else
                begin
                    res_next.status = STAT_NO_COMMAND;
                end
            end
            S_DELIVER:
            begin
                res = res_reg;
            end
            default:
            begin
                res = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            loaded_reg <= '0;
            marked_reg <= '0;
            for (int i = 0; i < SLAVE_ENTRIES; i++)
            begin
                last_slot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            loaded_reg    <= loaded_next;
            marked_reg    <= marked_next;
            last_slot_reg <= last_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        slave_idx_reg <= slave_idx_next;
    end

endmodule

### src/mrm_checker.sv
// port-level checks of the response matcher and their bind
`include "assert_macros.svh"

module mrm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [1:0]  rsp_kind,
    input logic [7:0]  rsp_station,
    input logic [15:0] rsp_start,
    input logic [15:0] rsp_quantity,
    input logic [1:0]  rsp_source,
    input logic [3:0]  rsp_slot
);
    import mrm_pkg::*;

    logic rsp_zero;

    assign rsp_zero = (rsp_kind == 2'd0) && (rsp_station == 8'd0) && (rsp_start == 16'd0)
                   && (rsp_quantity == 16'd0) && (rsp_source == SRC_OFFERED)
                   && (rsp_slot == 4'd0);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMPL(a_reject_zero, clk, rst_n, rsp_valid && (rsp_status != STAT_OK), rsp_zero)
    `ASSERT_IMPL(a_offered_slot, clk, rst_n, rsp_valid && (rsp_source == SRC_OFFERED), rsp_slot == 4'd0)

endmodule

bind modbus_response_matcher_top mrm_checker u_mrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_kind     (rsp.read_kind),
    .rsp_station  (rsp.station_out),
    .rsp_start    (rsp.start_out),
    .rsp_quantity (rsp.quantity_out),
    .rsp_source   (rsp.command_source),
    .rsp_slot     (rsp.matched_slot)
);

### bench/testbench.sv
// self-checking testbench for the modbus response matcher: predicts every result and compares
`timescale 1ns / 100ps

module testbench;
    import mrm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 40;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    mrm_req_if req_ch ();
    mrm_rsp_if rsp_ch ();

    modbus_response_matcher_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the matcher tables
    logic [7:0] station_tab [SLAVE_ENTRIES];
    cmd_t       cmd_tab     [CMD_DEPTH];
    bit         slot_used   [CMD_DEPTH];
    bit         mark_set    [SLAVE_ENTRIES];
    bit [3:0]   mark_slot   [SLAVE_ENTRIES];
    logic [4:0] active_slaves;

    res_t verdict_queue [$];
    int   mismatches;
    int   quiet_cycles;
    bit   steady_flow;
    bit   hold_request;

    function automatic logic [7:0] reply_length(input logic [7:0] fc, input logic [15:0] qty);
        logic [16:0] n;
        n = '0;
        if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE)
            n = (qty == 16'd0) ? 17'd1 : 17'((qty - 16'd1) >> 3) + 17'd1;
        else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT)
            n = {qty, 1'b0};
        return n[7:0];
    endfunction

    function automatic bit command_fits(input req_t r, input logic [7:0] cs,
                                        input logic [7:0] cf, input logic [15:0] cq);
        return (r.station_address == cs) && (r.function_code == cf)
            && (r.byte_count == reply_length(r.function_code, cq));
    endfunction

    // applies one request to the shadow tables and returns the result it must give
    function automatic res_t frame_verdict(input req_t r);
        res_t v;
        int   addr;
        int   span;
        int   base;
        int   slave_hit;
        int   slot_hit;
        bit [3:0] ls;
        v         = '0;
        slave_hit = -1;
        slot_hit  = -1;
        addr      = r.slave_index * SLOTS_PER_SLAVE + r.slot_index;
        case (op_e'(r.operation))
            OP_SET_SLAVE:
            begin
                station_tab[r.slave_index] = r.station_address;
            end
            OP_LOAD_SLOT:
            begin
                cmd_tab[addr]   = '{r.station_address, r.function_code, r.start_address,
                                    r.quantity};
                slot_used[addr] = 1'b1;
            end
            OP_MARK_LAST:
            begin
                mark_set[r.slave_index] = r.offered_valid;
                if (r.offered_valid)
                    mark_slot[r.slave_index] = r.slot_index;
            end
            default:
            begin
                if (r.function_code > FC_READ_INPUT)
                    v.status = STAT_NOT_READ;
                else if (r.function_code == 8'd0)
                    v.status = STAT_BAD_FUNCTION;
                else if (!r.frame_intact)
                    v.status = STAT_INTEGRITY;
                else if (r.offered_valid && command_fits(r, r.offered_station,
                                                         r.offered_function, r.quantity))
                begin
                    v.command_source = SRC_OFFERED;
                    v.start_out      = r.start_address;
                    v.quantity_out   = r.quantity;
                end
                else
                begin
                    span = (active_slaves > SLAVE_ENTRIES) ? SLAVE_ENTRIES : active_slaves;
                    for (int i = 0; i < span; i++)
                        if (slave_hit < 0 && station_tab[i] == r.station_address)
                            slave_hit = i;
                    if (slave_hit < 0)
                        v.status = STAT_UNKNOWN_SLAVE;
                    else
                    begin
                        base = slave_hit * SLOTS_PER_SLAVE;
                        ls   = mark_slot[slave_hit];
                        if (mark_set[slave_hit] && command_fits(r, cmd_tab[base + ls].station,
                                                                cmd_tab[base + ls].fcode,
                                                                cmd_tab[base + ls].quantity))
                        begin
                            v.command_source = SRC_LAST;
                            slot_hit         = ls;
                        end
                        else
                        begin
                            for (int j = 0; j < SLOTS_PER_SLAVE; j++)
                                if (slot_hit < 0 && slot_used[base + j]
                                    && command_fits(r, cmd_tab[base + j].station,
                                                    cmd_tab[base + j].fcode,
                                                    cmd_tab[base + j].quantity))
                                    slot_hit = j;
                            if (slot_hit < 0)
                                v.status = STAT_NO_COMMAND;
                            else
                                v.command_source = SRC_TABLE;
                        end
                        if (slot_hit >= 0)
                        begin
                            v.matched_slot = 4'(slot_hit);
                            v.start_out    = cmd_tab[base + slot_hit].start;
                            v.quantity_out = cmd_tab[base + slot_hit].quantity;
                        end
                    end
                end
                if (v.status == STAT_OK)
                begin
                    v.read_kind   = 2'(r.function_code - 8'd1);
                    v.station_out = r.station_address;
                end
            end
        endcase
        return v;
    endfunction

    function automatic req_t make_request(input op_e op, input logic [3:0] slave,
                                          input logic [3:0] slot, input logic [7:0] sta,
                                          input logic [7:0] fc, input logic [15:0] start,
                                          input logic [15:0] qty, input logic [7:0] bc,
                                          input logic intact, input logic ov,
                                          input logic [7:0] ost, input logic [7:0] ofc);
        return '{op, slave, slot, sta, fc, start, qty, bc, intact, ov, ost, ofc};
    endfunction

    function automatic logic [7:0] pool_station();
        logic [7:0] s;
        s = 8'($urandom);
        if ($urandom_range(99, 0) < 70)
        begin
            case ($urandom_range(5, 0))
                0: s = 8'h00;
                1: s = 8'h55;
                2: s = 8'hAA;
                3: s = 8'hFF;
                4: s = 8'h0F;
                default: s = 8'hF0;
            endcase
        end
        return s;
    endfunction

    // random table writes and matches; matches mostly fit the stored commands, rest noise
    function automatic req_t random_request();
        req_t r;
        int   roll;
        int   span;
        int   pick;
        int   base;
        int   loaded [$];
        r    = $bits(req_t)'({$urandom, $urandom, $urandom});
        roll = $urandom_range(99, 0);
        base = r.slave_index * SLOTS_PER_SLAVE;
        if (roll < 10)
        begin
            r.operation       = OP_SET_SLAVE;
            r.station_address = pool_station();
        end
        else if (roll < 30)
        begin
            r.operation = OP_LOAD_SLOT;
            r.station_address = ($urandom_range(99, 0) < 80) ? station_tab[r.slave_index]
                                                             : pool_station();
            if ($urandom_range(99, 0) < 85)
                r.function_code = 8'($urandom_range(4, 1));
            if ($urandom_range(1, 0) == 1)
                r.quantity = 16'($urandom_range(300, 0));
        end
        else if (roll < 45)
        begin
            r.operation = OP_MARK_LAST;
            if (!slot_used[base + r.slot_index])
                r.offered_valid = 1'b0;
        end
        else
        begin
            r.operation = OP_MATCH;
            span = (active_slaves > SLAVE_ENTRIES) ? SLAVE_ENTRIES : active_slaves;
            roll = $urandom_range(99, 0);
            if (roll < 60 && span > 0)
            begin
                pick = $urandom_range(span - 1, 0);
                base = pick * SLOTS_PER_SLAVE;
                for (int j = 0; j < SLOTS_PER_SLAVE; j++)
                    if (slot_used[base + j])
                        loaded.push_back(base + j);
                r.station_address = station_tab[pick];
                if (loaded.size() > 0)
                begin
                    pick            = loaded[$urandom_range(loaded.size() - 1, 0)];
                    r.function_code = cmd_tab[pick].fcode;
                    r.byte_count    = reply_length(cmd_tab[pick].fcode, cmd_tab[pick].quantity);
                end
                r.frame_intact = ($urandom_range(99, 0) < 95);
            end
            else if (roll < 75)
            begin
                r.station_address  = pool_station();
                r.function_code    = 8'($urandom_range(4, 1));
                r.byte_count       = reply_length(r.function_code, r.quantity);
                r.frame_intact     = 1'b1;
                r.offered_valid    = 1'b1;
                r.offered_station  = r.station_address;
                r.offered_function = r.function_code;
            end
            else
            begin
                if ($urandom_range(1, 0) == 1)
                    r.function_code = 8'($urandom_range(4, 1));
                r.frame_intact = ($urandom_range(99, 0) < 80);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] wanted);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %0h, wanted %0h", $time, what, seen, wanted);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input req_t r);
        while (!steady_flow && $urandom_range(99, 0) < 29)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.operation        <= r.operation;
        req_ch.slave_index      <= r.slave_index;
        req_ch.slot_index       <= r.slot_index;
        req_ch.station_address  <= r.station_address;
        req_ch.function_code    <= r.function_code;
        req_ch.start_address    <= r.start_address;
        req_ch.quantity         <= r.quantity;
        req_ch.byte_count       <= r.byte_count;
        req_ch.frame_intact     <= r.frame_intact;
        req_ch.offered_valid    <= r.offered_valid;
        req_ch.offered_station  <= r.offered_station;
        req_ch.offered_function <= r.offered_function;
        req_ch.valid            <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_slave_count(input logic [4:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we        <= 1'b0;
        active_slaves = value;
    endtask

    task automatic run_random(input int items);
        repeat (items) send_request(random_request());
    endtask

    task automatic test_basic_operations();
        // no slaves in use yet
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'd3, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(OP_SET_SLAVE, 0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_SET_SLAVE, 1, 0, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_SET_SLAVE, 2, 0, 8'h11, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_SET_SLAVE, 3, 0, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        write_slave_count(5'd4);
        send_request(make_request(OP_LOAD_SLOT, 0, 0, 8'h00, 8'd1, 16'h0000, 16'd0,
                                  0, 0, 0, 0, 0));
        send_request(make_request(OP_LOAD_SLOT, 1, 15, 8'hFF, 8'd4, 16'hFFFF, 16'hFFFF,
                                  0, 0, 0, 0, 0));
        send_request(make_request(OP_LOAD_SLOT, 1, 3, 8'hFF, 8'd3, 16'h1234, 16'd200,
                                  0, 0, 0, 0, 0));
        send_request(make_request(OP_LOAD_SLOT, 2, 5, 8'h11, 8'd2, 16'h8000, 16'd17,
                                  0, 0, 0, 0, 0));
        // rejects in order of precedence
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'd5, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'd0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'd1, 0, 0, 8'd1, 0, 0, 0, 0));
        // offered command hit and miss
        send_request(make_request(OP_MATCH, 0, 0, 8'h42, 8'd3, 16'hABCD, 16'd10, 8'd20,
                                  1, 1, 8'h42, 8'd3));
        send_request(make_request(OP_MATCH, 0, 0, 8'hAB, 8'd3, 16'hABCD, 16'd10, 8'd20,
                                  1, 1, 8'h42, 8'd3));
        // coil read with zero quantity, then a scan past unloaded slots
        send_request(make_request(OP_MATCH, 0, 0, 8'h00, 8'd1, 0, 0, 8'd1, 1, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'hFF, 8'd4, 0, 0, 8'hFE, 1, 0, 0, 0));
        send_request(make_request(OP_MARK_LAST, 1, 3, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'hFF, 8'd3, 0, 0, 8'h90, 1, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'hFF, 8'd4, 0, 0, 8'hFE, 1, 0, 0, 0));
        // clearing the mark keeps the slot, which then goes unused
        send_request(make_request(OP_MARK_LAST, 1, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'hFF, 8'd3, 0, 0, 8'h90, 1, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'h11, 8'd2, 0, 0, 8'd4, 1, 0, 0, 0));
        send_request(make_request(OP_MATCH, 0, 0, 8'h11, 8'd2, 0, 0, 8'd3, 1, 0, 0, 0));
    endtask

    task automatic test_table_fill();
        req_t r;
        for (int i = 0; i < SLAVE_ENTRIES; i++)
            send_request(make_request(OP_SET_SLAVE, 4'(i), 0, pool_station(), 0, 0, 0,
                                      0, 0, 0, 0, 0));
        repeat (48)
        begin
            r                 = random_request();
            r.operation       = OP_LOAD_SLOT;
            r.station_address = station_tab[r.slave_index];
            r.function_code   = 8'($urandom_range(4, 1));
            send_request(r);
        end
    endtask

    task automatic test_count_limits();
        write_slave_count(5'd31);
        run_random(250);
        write_slave_count(5'd0);
        run_random(80);
        write_slave_count(5'd1);
        run_random(120);
        write_slave_count(5'd16);
        run_random(200);
    endtask

    task automatic test_steady_stream();
        write_slave_count(5'd12);
        steady_flow = 1'b1;
        run_random(300);
        steady_flow = 1'b0;
    endtask

    task automatic test_output_stall();
        write_slave_count(5'd9);
        hold_request = 1'b1;
        run_random(150);
    endtask

    task automatic test_random_counts();
        repeat (4)
        begin
            write_slave_count(5'($urandom_range(31, 0)));
            run_random(110);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_t wanted;
        req_t taken;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (verdict_queue.size() == 0)
                    report_mismatch("unrequested result", 16'(rsp_ch.status), 16'd0);
                else
                begin
                    wanted = verdict_queue.pop_front();
                    if (rsp_ch.status !== wanted.status)
                        report_mismatch("status", 16'(rsp_ch.status), 16'(wanted.status));
                    if (rsp_ch.read_kind !== wanted.read_kind)
                        report_mismatch("read_kind", 16'(rsp_ch.read_kind),
                                        16'(wanted.read_kind));
                    if (rsp_ch.station_out !== wanted.station_out)
                        report_mismatch("station_out", 16'(rsp_ch.station_out),
                                        16'(wanted.station_out));
                    if (rsp_ch.start_out !== wanted.start_out)
                        report_mismatch("start_out", rsp_ch.start_out, wanted.start_out);
                    if (rsp_ch.quantity_out !== wanted.quantity_out)
                        report_mismatch("quantity_out", rsp_ch.quantity_out,
                                        wanted.quantity_out);
                    if (rsp_ch.command_source !== wanted.command_source)
                        report_mismatch("command_source", 16'(rsp_ch.command_source),
                                        16'(wanted.command_source));
                    if (rsp_ch.matched_slot !== wanted.matched_slot)
                        report_mismatch("matched_slot", 16'(rsp_ch.matched_slot),
                                        16'(wanted.matched_slot));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken = '{req_ch.operation, req_ch.slave_index, req_ch.slot_index,
                          req_ch.station_address, req_ch.function_code, req_ch.start_address,
                          req_ch.quantity, req_ch.byte_count, req_ch.frame_intact,
                          req_ch.offered_valid, req_ch.offered_station,
                          req_ch.offered_function};
                verdict_queue.push_back(frame_verdict(taken));
            end
        end
    end

    // result side: random stalls, and one long hold when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= steady_flow || ($urandom_range(99, 0) >= 29);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        req_ch.valid            = 1'b0;
        req_ch.operation        = '0;
        req_ch.slave_index      = '0;
        req_ch.slot_index       = '0;
        req_ch.station_address  = '0;
        req_ch.function_code    = '0;
        req_ch.start_address    = '0;
        req_ch.quantity         = '0;
        req_ch.byte_count       = '0;
        req_ch.frame_intact     = 1'b0;
        req_ch.offered_valid    = 1'b0;
        req_ch.offered_station  = '0;
        req_ch.offered_function = '0;
        active_slaves           = '0;
        mismatches              = 0;
        steady_flow             = 1'b0;
        hold_request            = 1'b0;
        for (int i = 0; i < SLAVE_ENTRIES; i++)
        begin
            mark_set[i]  = 1'b0;
            mark_slot[i] = '0;
        end
        for (int i = 0; i < CMD_DEPTH; i++)
            slot_used[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_operations();
        test_table_fill();
        test_count_limits();
        test_steady_stream();
        test_output_stall();
        test_random_counts();

        wait_drained();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/mrm_pkg.sv
src/mrm_req_if.sv
src/mrm_rsp_if.sv
src/mrm_ram.sv
src/mrm_seq.sv
src/modbus_response_matcher_top.sv
src/mrm_checker.sv
bench/testbench.sv
